[design/chte_pkg.sv]
// chte_pkg: shared types and codes of the chained hash table engine
// no dependencies; imported by chained_hash_table_engine, chte_table_checker and the testbench
package chte_pkg;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // result codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // one stored record, 60 bits
  typedef struct packed {
    logic [15:0] key;
    logic [3:0]  doors;
    logic [31:0] price;
    logic [7:0]  series;
  } rec_t;

  localparam int unsigned CntW      = 5;   // bucket_count register width
  localparam int unsigned HashW     = 20;  // key*5 padded to an even width
  localparam int unsigned HashSteps = HashW / 2;  // two dividend bits per cycle
  localparam logic [CntW-1:0] CntReset = 5'd3;

endpackage

[design/chained_hash_table_engine.sv]
// chained_hash_table_engine: bucketed record table with insert, delete and read
// depends on chte_pkg for record type, operation and status codes
//
// flow: a read passes the read-data state on its way to the output register, or goes
//   there at once when the bucket is out of range or the slot is empty; a no-op goes
//   there at once; insert and delete run the hash remainder unit (2 bits a cycle),
//   then the chain walk, and an insert to a full bucket skips the walk
// one item at a time: the next beat is taken in the cycle after the result is loaded
// reset: async active low, every bucket empty, bucket_count = 3; no clearing pass
module chained_hash_table_engine import chte_pkg::*; #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned WAYS    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [15:0]       key_id_i,
  input  logic [3:0]        door_count_i,
  input  logic [31:0]       price_bits_i,
  input  logic [7:0]        series_code_i,
  input  logic [3:0]        bucket_sel_i,
  input  logic [2:0]        position_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [15:0]       out_id_o,
  output logic [3:0]        out_doors_o,
  output logic [31:0]       out_price_o,
  output logic [7:0]        out_series_o
);

  // geometry: each bucket owns a power-of-two run of slots in the record memory
  localparam int unsigned BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned FW        = $clog2(WAYS + 1);
  localparam int unsigned AW        = BW + SW;
  localparam int unsigned MEM_DEPTH = BUCKETS << SW;
  localparam int unsigned CW        = FW + 3;
  localparam logic [FW-1:0] WAYS_F  = FW'(WAYS);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HASH     = 4'd1;  // remainder unit running
  localparam logic [3:0] S_DISP     = 4'd2;  // bucket known, look at its fill
  localparam logic [3:0] S_INS_SH   = 4'd3;  // move records one slot down
  localparam logic [3:0] S_INS_HEAD = 4'd4;  // write new record at slot 0
  localparam logic [3:0] S_DEL_SCAN = 4'd5;  // search for the key
  localparam logic [3:0] S_DEL_SH   = 4'd6;  // close the gap
  localparam logic [3:0] S_RD_MEM   = 4'd7;  // read data arrives
  localparam logic [3:0] S_FIN      = 4'd8;  // hand result to output register

  logic [3:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     eff_cnt;

  // captured request
  logic [1:0]          func_q;
  rec_t                new_rec_q;

  // hash remainder unit
  logic [HashW-1:0]    prod_q, prod_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [3:0]          step_q, step_d;

  // chain walk
  logic [BW-1:0]       bkt_q, bkt_d;
  logic [FW-1:0]       idx_q, idx_d;
  logic [SW-1:0]       wslot_q, wslot_d;
  logic                pend_q, pend_d;

  // bucket fill counters
  logic [FW-1:0]       fill_q [BUCKETS];
  logic [FW-1:0]       cur_fill;
  logic                fill_inc, fill_dec;

  // result staging and output register
  logic [1:0]          res_status_q, res_status_d;
  rec_t                res_rec_q, res_rec_d;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  rec_t                out_rec_q;
  logic                out_load;

  // record memory, one write and one registered read port
  rec_t                mem [MEM_DEPTH];
  rec_t                rd_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  rec_t                mem_wdata;

  // request side decode
  logic                in_fire;
  logic [BW-1:0]       sel_idx;
  logic                sel_range_bad, sel_pos_bad;
  logic                scan_hit;

  // one restoring remainder step on a single dividend bit
  function automatic logic [CntW-1:0] mod_step(logic [CntW-1:0] r, logic b,
                                               logic [CntW-1:0] n);
    logic [CntW:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[CntW-1:0];
  endfunction

  // effective divisor: zero reads as one, clamp at the bucket count
  assign eff_cnt = (cnt_q == '0) ? CntW'(1) :
                   ((32'(cnt_q) > BUCKETS) ? CntW'(BUCKETS) : cnt_q);

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign sel_idx       = BW'(bucket_sel_i);
  assign sel_range_bad = ({1'b0, bucket_sel_i} >= eff_cnt);
  assign sel_pos_bad   = (CW'(position_i) >= CW'(fill_q[sel_idx]));
  assign cur_fill      = fill_q[bkt_q];
  assign scan_hit      = pend_q && (rd_q.key == new_rec_q.key);
  assign out_load      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d      = state_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    step_d       = step_q;
    bkt_d        = bkt_q;
    idx_d        = idx_q;
    wslot_d      = wslot_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    fill_inc     = 1'b0;
    fill_dec     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = {bkt_q, SW'(idx_q)};
    mem_wdata    = rd_q;
    mem_raddr    = {bkt_q, SW'(idx_q)};

    unique case (state_q)
      S_IDLE: begin
        // read port looks at the requested slot right away
        mem_raddr = {sel_idx, SW'(position_i)};
        if (in_fire) begin
          res_status_d = ST_OK;
          res_rec_d    = '0;
          prod_d       = HashW'({key_id_i, 2'b00}) + HashW'(key_id_i);
          rem_d        = '0;
          step_d       = '0;
          unique case (func_i)
            FUNC_INSERT, FUNC_DELETE: state_d = S_HASH;
            FUNC_READ: begin
              if (sel_range_bad) begin
                res_status_d = ST_RANGE;
                state_d      = S_FIN;
              end else if (sel_pos_bad) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_FIN;
              end else begin
                state_d = S_RD_MEM;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_HASH: begin
        // two dividend bits per cycle, msb first
        rem_d  = mod_step(mod_step(rem_q, prod_q[HashW-1], eff_cnt),
                          prod_q[HashW-2], eff_cnt);
        prod_d = {prod_q[HashW-3:0], 2'b00};
        step_d = step_q + 4'd1;
        if (step_q == 4'(HashSteps - 1)) begin
          bkt_d   = BW'(rem_d);
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        pend_d = 1'b0;
        if (func_q == FUNC_INSERT) begin
          if (cur_fill >= WAYS_F) begin
            res_status_d = ST_FULL;
            state_d      = S_FIN;
          end else begin
            idx_d   = cur_fill;
            state_d = S_INS_SH;
          end
        end else begin
          idx_d   = '0;
          state_d = S_DEL_SCAN;
        end
      end

      S_INS_SH: begin
        // read slot idx-1 while the slot read last cycle lands one lower
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {bkt_q, SW'(idx_q + FW'(1))};
          mem_wdata = rd_q;
        end
        if (idx_q != '0) begin
          mem_raddr = {bkt_q, SW'(idx_q - FW'(1))};
          idx_d     = idx_q - FW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INS_HEAD;
        end
      end

      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = {bkt_q, SW'(0)};
        mem_wdata = new_rec_q;
        fill_inc  = 1'b1;
        state_d   = S_FIN;
      end

      S_DEL_SCAN: begin
        // compare last beat's read, issue the next one
        if (scan_hit) begin
          pend_d  = 1'b0;
          state_d = S_DEL_SH;
        end else if (idx_q == cur_fill) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_FIN;
        end else begin
          mem_raddr = {bkt_q, SW'(idx_q)};
          idx_d     = idx_q + FW'(1);
          pend_d    = 1'b1;
        end
      end

      S_DEL_SH: begin
        // idx points one past the hole; each record moves up one slot
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {bkt_q, wslot_q};
          mem_wdata = rd_q;
        end
        if (idx_q == cur_fill) begin
          fill_dec = 1'b1;
          pend_d   = 1'b0;
          state_d  = S_FIN;
        end else begin
          mem_raddr = {bkt_q, SW'(idx_q)};
          wslot_d   = SW'(idx_q - FW'(1));
          idx_d     = idx_q + FW'(1);
          pend_d    = 1'b1;
        end
      end

      S_RD_MEM: begin
        res_rec_d = rd_q;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CntReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // bucket fill counters, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_inc) begin
      fill_q[bkt_q] <= cur_fill + FW'(1);
    end else if (fill_dec) begin
      fill_q[bkt_q] <= cur_fill - FW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    rem_q        <= rem_d;
    step_q       <= step_d;
    bkt_q        <= bkt_d;
    idx_q        <= idx_d;
    wslot_q      <= wslot_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    if (in_fire) begin
      func_q           <= func_i;
      new_rec_q.key    <= key_id_i;
      new_rec_q.doors  <= door_count_i;
      new_rec_q.price  <= price_bits_i;
      new_rec_q.series <= series_code_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_rec_q    <= res_rec_q;
    end
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_id_o     = out_rec_q.key;
  assign out_doors_o  = out_rec_q.doors;
  assign out_price_o  = out_rec_q.price;
  assign out_series_o = out_rec_q.series;

endmodule

[tb/chte_table_checker.sv]
`timescale 1ns / 1ps
// chte_table_checker: watches the ports of chained_hash_table_engine, keeps its own copy
// of the bucket chains, predicts each result beat and compares it field by field
// depends on chte_pkg for the record type, operation and status codes
module chte_table_checker import chte_pkg::*; #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned WAYS    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [1:0]      func_i,
  input  logic [15:0]     key_id_i,
  input  logic [3:0]      door_count_i,
  input  logic [31:0]     price_bits_i,
  input  logic [7:0]      series_code_i,
  input  logic [3:0]      bucket_sel_i,
  input  logic [2:0]      position_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [1:0]      status_i,
  input  logic [15:0]     out_id_i,
  input  logic [3:0]      out_doors_i,
  input  logic [31:0]     out_price_i,
  input  logic [7:0]      out_series_i,
  output int              mismatch_cnt_o,
  output int              pending_o,
  output int              checked_o
);

  localparam int unsigned HashMul = 5;

  typedef struct packed {
    status_e status;
    rec_t    rec;
  } reply_t;

  logic [CntW-1:0] bucket_count_q;
  int unsigned     chain_len [BUCKETS];
  rec_t            chain_mem [BUCKETS*WAYS];
  reply_t          due_replies [$];
  int              mismatches;
  int              checked;

  function automatic int unsigned live_buckets();
    int unsigned n;
    n = 32'(bucket_count_q);
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    return n;
  endfunction

  function automatic int unsigned home_bucket(logic [15:0] key);
    int unsigned k;
    k = 32'(key);
    return (k * HashMul) % live_buckets();
  endfunction

  // updates the chains for one request and returns the reply it must produce
  function automatic reply_t apply_request(func_e op, logic [15:0] key, logic [3:0] doors,
                                           logic [31:0] price, logic [7:0] series,
                                           logic [3:0] bsel, logic [2:0] pos);
    reply_t      r;
    rec_t        fresh;
    int unsigned b, f, i, hit;
    r.status = ST_OK;
    r.rec    = '0;
    case (op)
      FUNC_INSERT: begin
        b = home_bucket(key);
        f = chain_len[b];
        if (f >= WAYS) begin
          r.status = ST_FULL;
        end else begin
          for (i = f; i > 0; i--) chain_mem[b*WAYS+i] = chain_mem[b*WAYS+i-1];
          fresh.key    = key;
          fresh.doors  = doors;
          fresh.price  = price;
          fresh.series = series;
          chain_mem[b*WAYS] = fresh;
          chain_len[b] = f + 1;
        end
      end
      FUNC_DELETE: begin
        b   = home_bucket(key);
        f   = chain_len[b];
        hit = f;
        // first match counted from the head
        for (i = 0; i < f; i++)
          if (hit == f && chain_mem[b*WAYS+i].key == key) hit = i;
        if (hit == f) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < f; i++) chain_mem[b*WAYS+i] = chain_mem[b*WAYS+i+1];
          chain_mem[b*WAYS+f-1] = '0;
          chain_len[b] = f - 1;
        end
      end
      FUNC_READ: begin
        b = 32'(bsel);
        if (b >= live_buckets()) r.status = ST_RANGE;
        else if (pos >= chain_len[b]) r.status = ST_NOT_FOUND;
        else r.rec = chain_mem[b*WAYS+pos];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      bucket_count_q = CntReset;
      for (int b = 0; b < BUCKETS; b++) chain_len[b] = 0;
      due_replies.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_we_i) bucket_count_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        due_replies.push_back(apply_request(func_e'(func_i), key_id_i, door_count_i,
                                            price_bits_i, series_code_i, bucket_sel_i,
                                            position_i));
      if (out_valid_i && out_ready_i) begin
        if (due_replies.size() == 0) begin
          $error("result beat with no request waiting: status %0d id %0h", status_i, out_id_i);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("out_id", 32'(want.rec.key), 32'(out_id_i));
          check_field("out_doors", 32'(want.rec.doors), 32'(out_doors_i));
          check_field("out_price", want.rec.price, out_price_i);
          check_field("out_series", 32'(want.rec.series), 32'(out_series_i));
          checked++;
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= due_replies.size();
    checked_o      <= checked;
  end

endmodule

[tb/tb_chained_hash_table_engine.sv]
`timescale 1ns / 1ps
// tb_chained_hash_table_engine: drives requests and bucket-count writes into the engine
// and gives the verdict; prediction and comparison live in chte_table_checker
// depends on chte_pkg, chained_hash_table_engine and chte_table_checker
module tb_chained_hash_table_engine;
  import chte_pkg::*;

  localparam int unsigned BUCKETS         = 16;
  localparam int unsigned WAYS            = 8;
  localparam int          PHASES          = 10;
  localparam int          ITEMS_PER_PHASE = 100;
  // covers the longest request, a chain walk over a full bucket, plus margin
  localparam int          SETTLE_CYCLES   = 40;
  // limit sits far above the longest quiet stretch of a correct run
  localparam int          WATCHDOG_LIMIT  = 2000;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            cfg_we     = 1'b0;
  logic [CntW-1:0] cfg_wdata  = '0;
  logic            req_valid  = 1'b0;
  logic            req_ready;
  logic [1:0]      func       = '0;
  logic [15:0]     key_id     = '0;
  logic [3:0]      door_count = '0;
  logic [31:0]     price_bits = '0;
  logic [7:0]      series     = '0;
  logic [3:0]      bucket_sel = '0;
  logic [2:0]      position   = '0;
  logic            out_valid;
  logic            out_ready  = 1'b0;
  logic [1:0]      status;
  logic [15:0]     out_id;
  logic [3:0]      out_doors;
  logic [31:0]     out_price;
  logic [7:0]      out_series;

  int mismatch_cnt;
  int pending;
  int checked;

  // idle knobs, percent chance per beat / per cycle
  int gap_pct      = 0;
  int rx_stall_pct = 0;
  int rx_hold;
  int quiet_cycles = 0;
  int sent         = 0;
  int directed_cnt;

  // bucket-count settings walked by the random phases, extremes included
  int unsigned phase_counts [PHASES] = '{1, 16, 0, 31, 17, 5, 2, 9, 16, 3};
  logic [15:0] key_pool [16];

  always #5 clk = ~clk;

  chained_hash_table_engine #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .func_i        (func),
    .key_id_i      (key_id),
    .door_count_i  (door_count),
    .price_bits_i  (price_bits),
    .series_code_i (series),
    .bucket_sel_i  (bucket_sel),
    .position_i    (position),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_id_o      (out_id),
    .out_doors_o   (out_doors),
    .out_price_o   (out_price),
    .out_series_o  (out_series)
  );

  chte_table_checker #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (req_valid),
    .in_ready_i     (req_ready),
    .func_i         (func),
    .key_id_i       (key_id),
    .door_count_i   (door_count),
    .price_bits_i   (price_bits),
    .series_code_i  (series),
    .bucket_sel_i   (bucket_sel),
    .position_i     (position),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .out_id_i       (out_id),
    .out_doors_i    (out_doors),
    .out_price_i    (out_price),
    .out_series_i   (out_series),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // result side: random stall bursts, none when rx_stall_pct is 0
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      out_ready <= 1'b0;
      rx_hold   <= $urandom_range(11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_valid && req_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d results still due", quiet_cycles, pending);
        $display("tb_chained_hash_table_engine: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // holds one request beat until it is taken, then maybe opens a gap;
  // valid stays high when the next beat follows at once
  task automatic send_request(func_e op, logic [15:0] key, logic [3:0] doors,
                              logic [31:0] price, logic [7:0] code,
                              logic [3:0] bsel, logic [2:0] pos);
    req_valid  <= 1'b1;
    func       <= op;
    key_id     <= key;
    door_count <= doors;
    price_bits <= price;
    series     <= code;
    bucket_sel <= bsel;
    position   <= pos;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
    if ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // sender pauses until every result has come back, then lets the engine go quiet
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CntW-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random request, mostly well formed: keys from a small pool so deletes hit
  // and chains fill up, reads aimed at buckets in use
  task automatic send_random(int unsigned live_n);
    func_e       op;
    int          pick;
    logic [15:0] key;
    logic [3:0]  bsel;
    logic [2:0]  pos;
    pick = $urandom_range(99);
    if (pick < 40) op = FUNC_INSERT;
    else if (pick < 68) op = FUNC_DELETE;
    else if (pick < 95) op = FUNC_READ;
    else op = FUNC_NOP;
    key  = ($urandom_range(9) == 0) ? 16'($urandom) : key_pool[$urandom_range(15)];
    bsel = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(live_n - 1));
    pos  = ($urandom_range(1) == 0) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
    send_request(op, key, 4'($urandom), $urandom, 8'($urandom), bsel, pos);
  endtask

  initial begin
    int unsigned live_n;
    int          p;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset bucket count of 3
    gap_pct      = 20;
    rx_stall_pct <= 20;
    // empty bucket, out-of-range buckets, no-op with all fields high
    send_request(FUNC_READ, '0, '0, '0, '0, 4'd0, 3'd0);
    send_request(FUNC_READ, '0, '0, '0, '0, 4'hF, 3'h7);
    send_request(FUNC_READ, '0, '0, '0, '0, 4'd3, 3'd0);
    send_request(FUNC_NOP, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 3'h7);
    // extreme records, both land in bucket 0, then a duplicate key
    send_request(FUNC_INSERT, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, '0, '0);
    send_request(FUNC_INSERT, 16'h0000, 4'h0, 32'h0000_0000, 8'h00, '0, '0);
    send_request(FUNC_INSERT, 16'h0000, 4'h5, 32'h3F80_0000, 8'h41, '0, '0);
    // newest first
    for (int i = 0; i < 3; i++) send_request(FUNC_READ, '0, '0, '0, '0, 4'd0, 3'(i));
    // delete takes the newest duplicate, older one moves up
    send_request(FUNC_DELETE, 16'h0000, '0, '0, '0, '0, '0);
    send_request(FUNC_READ, '0, '0, '0, '0, 4'd0, 3'd0);
    // absent key
    send_request(FUNC_DELETE, 16'd1234, '0, '0, '0, '0, '0);
    // multiples of 3 all hash to bucket 0: fill it, then overflow it
    for (int i = 1; i <= 7; i++)
      send_request(FUNC_INSERT, 16'(3 * i), 4'(i), 32'(i * 32'h0101_0101), 8'(i), '0, '0);
    send_request(FUNC_READ, '0, '0, '0, '0, 4'd0, 3'd7);
    send_request(FUNC_READ, '0, '0, '0, '0, 4'd1, 3'd0);
    directed_cnt = sent;

    foreach (key_pool[k]) key_pool[k] = 16'($urandom);

    // random phases, each at its own bucket count; the chains carry over, so
    // count changes strand records in buckets that go out of range
    for (p = 0; p < PHASES; p++) begin
      write_bucket_count(CntW'(phase_counts[p]));
      live_n = (phase_counts[p] == 0) ? 1 :
               (phase_counts[p] > BUCKETS) ? BUCKETS : phase_counts[p];
      for (int k = 0; k < 8; k++) key_pool[$urandom_range(15)] = 16'($urandom);
      // every third phase and the last one run without idling
      if (p == PHASES - 1 || p % 3 == 1) begin
        gap_pct      = 0;
        rx_stall_pct <= 0;
      end else begin
        gap_pct      = $urandom_range(10, 40);
        rx_stall_pct <= $urandom_range(10, 40);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random(live_n);
    end

    wait_drained();
    $display("covered %0d requests (%0d directed) over %0d bucket-count settings",
             sent, directed_cnt, PHASES + 1);
    $display("%0d result beats compared, %0d mismatches", checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_chained_hash_table_engine: PASS");
    end else begin
      $display("tb_chained_hash_table_engine: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/chte_pkg.sv
design/chained_hash_table_engine.sv
tb/chte_table_checker.sv
tb/tb_chained_hash_table_engine.sv
